/* rtl/core/aoc_pkg.sv */
// shared constants and types for the alpha over composite pipeline
package aoc_pkg;

    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned CH_W       = 8;
    localparam int unsigned W_W        = 16;
    localparam int unsigned NUM_W      = 24;
    localparam int unsigned LANES      = 3;

    typedef logic [CH_W-1:0]  chan_t;
    typedef logic [W_W-1:0]   wgt_t;
    typedef logic [NUM_W-1:0] num_t;

    typedef struct packed {
        num_t  rem;
        wgt_t  dvs;
        chan_t quo;
    } div_lane_t;

endpackage

/* rtl/core/alpha_over_composite.sv */
// porter-duff over composite of two straight-alpha rgba8 pixels, fully pipelined
// the done strobe follows the start transfer through the input, weight, product and load registers and the divider
// throughput: one pixel pair per cycle through the 8-stage restoring divider
// busy is always low: the pipeline never stalls since results cannot be held off
// reset: rst_n asynchronously clears all valid bits; payload registers are not reset
module alpha_over_composite
    import aoc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] top_red,
    input  logic [7:0] top_green,
    input  logic [7:0] top_blue,
    input  logic [7:0] top_alpha,
    input  logic [7:0] bottom_red,
    input  logic [7:0] bottom_green,
    input  logic [7:0] bottom_blue,
    input  logic [7:0] bottom_alpha,
    output logic       done,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic [7:0] out_alpha
);

    localparam int unsigned DSTAGES = CH_W;

    // stage 0: input registers
    logic  v_in_reg;
    chan_t tc_reg [3];
    chan_t bc_reg [3];
    chan_t ta_reg;
    chan_t ba_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_in_reg <= 1'b0;
        else
            v_in_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        tc_reg[0] <= top_red;
        tc_reg[1] <= top_green;
        tc_reg[2] <= top_blue;
        bc_reg[0] <= bottom_red;
        bc_reg[1] <= bottom_green;
        bc_reg[2] <= bottom_blue;
        ta_reg    <= top_alpha;
        ba_reg    <= bottom_alpha;
    end

    // stage 1: layer weights
    logic  v_w_reg;
    wgt_t  wt_reg;
    wgt_t  wb_reg;
    chan_t tc1_reg [3];
    chan_t bc1_reg [3];
    chan_t inv_ta;

    assign inv_ta = chan_t'(FULL_SCALE) - ta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_w_reg <= 1'b0;
        else
            v_w_reg <= v_in_reg;
    end

    always_ff @(posedge clk)
    begin
        wt_reg  <= W_W'(ta_reg) * W_W'(FULL_SCALE);
        wb_reg  <= W_W'(ba_reg) * W_W'(inv_ta);
        tc1_reg <= tc_reg;
        bc1_reg <= bc_reg;
    end

    // stage 2: per-channel products
    logic v_p_reg;
    num_t pt_reg [3];
    num_t pb_reg [3];
    wgt_t wt2_reg;
    wgt_t wb2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_p_reg <= 1'b0;
        else
            v_p_reg <= v_w_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            pt_reg[c] <= NUM_W'(tc1_reg[c]) * NUM_W'(wt_reg);
            pb_reg[c] <= NUM_W'(bc1_reg[c]) * NUM_W'(wb_reg);
        end
        wt2_reg <= wt_reg;
        wb2_reg <= wb_reg;
    end

    // stage 3: numerators and total weight, loaded into the divider lanes
    logic         v_s_reg;
    logic         zero_s_reg;
    chan_t        alpha_s_reg;
    div_lane_t    lane_s_reg [LANES];
    wgt_t         weight;
    logic [W_W:0] w_inc;
    logic [W_W:0] a_sum;

    assign weight = wt2_reg + wb2_reg;

    // divide by 255 as (x + 1 + ((x + 1) >> 8)) >> 8, exact over the weight range
    assign w_inc = {1'b0, weight} + (W_W+1)'(1);
    assign a_sum = w_inc + (w_inc >> CH_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_s_reg <= 1'b0;
        else
            v_s_reg <= v_p_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            lane_s_reg[c].rem <= pt_reg[c] + pb_reg[c];
            lane_s_reg[c].dvs <= weight;
            lane_s_reg[c].quo <= '0;
        end
        alpha_s_reg <= a_sum[2*CH_W-1:CH_W];
        zero_s_reg  <= (weight == '0);
    end

    // restoring divider, one quotient bit per stage, msb first
    logic      v_d_reg     [DSTAGES];
    logic      zero_d_reg  [DSTAGES];
    chan_t     alpha_d_reg [DSTAGES];
    div_lane_t lane_d_reg  [DSTAGES][LANES];

    for (genvar k = 0; k < DSTAGES; k++)
    begin : g_div
        localparam int unsigned SH = DSTAGES - 1 - k;

        logic      v_prev;
        logic      z_prev;
        chan_t     a_prev;
        div_lane_t l_prev [LANES];
        div_lane_t l_next [LANES];

        if (k == 0)
        begin : g_first
            assign v_prev = v_s_reg;
            assign z_prev = zero_s_reg;
            assign a_prev = alpha_s_reg;
            assign l_prev = lane_s_reg;
        end
        else
        begin : g_rest
            assign v_prev = v_d_reg[k-1];
            assign z_prev = zero_d_reg[k-1];
            assign a_prev = alpha_d_reg[k-1];
            assign l_prev = lane_d_reg[k-1];
        end

        always_comb
        begin
            logic [NUM_W:0] trial;
            for (int c = 0; c < LANES; c++)
            begin
                trial = (NUM_W+1)'(l_prev[c].dvs) << SH;
                l_next[c] = l_prev[c];
                if ({1'b0, l_prev[c].rem} >= trial)
                begin
                    l_next[c].rem = l_prev[c].rem - trial[NUM_W-1:0];
                    l_next[c].quo[SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_d_reg[k] <= 1'b0;
            else
                v_d_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            lane_d_reg[k]  <= l_next;
            zero_d_reg[k]  <= z_prev;
            alpha_d_reg[k] <= a_prev;
        end
    end

    // zero total weight forces every field to zero
    logic last_zero;
    assign last_zero = zero_d_reg[DSTAGES-1];

    assign done      = v_d_reg[DSTAGES-1];
    assign out_red   = last_zero ? '0 : lane_d_reg[DSTAGES-1][0].quo;
    assign out_green = last_zero ? '0 : lane_d_reg[DSTAGES-1][1].quo;
    assign out_blue  = last_zero ? '0 : lane_d_reg[DSTAGES-1][2].quo;
    assign out_alpha = last_zero ? '0 : alpha_d_reg[DSTAGES-1];

    // the strobe is the loaded divider valid carried through every divider stage
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(v_s_reg, DSTAGES))
        else $error("done strobe out of step with divider input");

    // a full-weight composite comes out fully opaque
    a_opaque_top: assert property (@(posedge clk) disable iff (!rst_n)
        (v_s_reg && alpha_s_reg == 8'd255) |->
        ##(DSTAGES) (done && out_alpha == 8'd255))
        else $error("opaque composite lost alpha");

    // a transfer is never refused
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised on a stall-free pipeline");

endmodule
